// File: src/double_ended_list_with_search_defines.svh
// Assertion macros used by the verification checker of the double-ended list.
// Needs a clk and an active-low arst_n in the scope where a macro is used.
`ifndef DOUBLE_ENDED_LIST_WITH_SEARCH_DEFINES_SVH
`define DOUBLE_ENDED_LIST_WITH_SEARCH_DEFINES_SVH

// Clocked property, switched off while reset is asserted.
`define DELS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication form of the macro above.
`define DELS_ASSERT_IMP(lbl, ante, cons, msg) \
	`DELS_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: src/dels_pkg.sv
// Types and constants of the double-ended list with search.
// Used by the interfaces, the top level and the checker; depends on nothing.
package dels_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int FUNC_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int CLASS_W  = 2;
	localparam int COUNT_W  = 5;

	localparam int COUNT_MAX = 31;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUSH_BACK  = 3'd0,
		FUNC_PUSH_FRONT = 3'd1,
		FUNC_POP_FRONT  = 3'd2,
		FUNC_POP_BACK   = 3'd3,
		FUNC_SEARCH     = 3'd4
	} dels_func_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} dels_status_t;

	typedef enum logic [CLASS_W-1:0] {
		CLASS_ABSENT = 2'd0,
		CLASS_UNIQUE = 2'd1,
		CLASS_DUP    = 2'd2
	} dels_class_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} dels_state_t;

endpackage

// File: src/dels_req_if.sv
// Request channel of the double-ended list: operation and value.
// Depends on dels_pkg for the field widths.
interface dels_req_if;
	logic                              valid;
	logic                              ready;
	logic [dels_pkg::FUNC_W-1:0]       func;
	logic signed [dels_pkg::VALUE_W-1:0] value;

	modport source (output valid, func, value, input ready);
	modport sink   (input valid, func, value, output ready);
endinterface

// File: src/dels_rsp_if.sv
// Response channel of the double-ended list: status and search result.
// Depends on dels_pkg for the field widths.
interface dels_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [dels_pkg::STATUS_W-1:0] status;
	logic [dels_pkg::CLASS_W-1:0]  match_class;
	logic [dels_pkg::COUNT_W-1:0]  match_count;

	modport source (output valid, status, match_class, match_count, input ready);
	modport sink   (input valid, status, match_class, match_count, output ready);
endinterface

// File: src/double_ended_list_with_search.sv
// Top level of the bounded double-ended list with a match-counting search.
// Depends on dels_pkg, dels_req_if and dels_rsp_if.
//
//   channel  direction  word contents
//   req      in         func, value
//   rsp      out        status, match_class, match_count
//
// Pushes, pops, unknown operations and a search of an empty list load their word on acceptance;
// it is offered the next cycle. A search of a nonempty list holds the block until its scan ends,
// since the entry memory has one read port and is scanned one entry per cycle.
// Reset clears the pointers, the occupancy and the output valid flag; no memory clear is needed.
// A stalled response word holds in the output register and blocks only the next request.
module double_ended_list_with_search #(
	parameter int CAPACITY = dels_pkg::CAPACITY_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	dels_req_if.sink        req,
	dels_rsp_if.source      rsp
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = IDX_W + 1;
	localparam int SAT_W = (CNT_W > dels_pkg::COUNT_W) ? CNT_W : dels_pkg::COUNT_W;

	logic [dels_pkg::VALUE_W-1:0] entries_mem [CAPACITY];

	dels_pkg::dels_state_t state_q, state_d;
	logic [IDX_W-1:0] front_q, front_d;
	logic [CNT_W-1:0] occ_q, occ_d;

	logic [dels_pkg::VALUE_W-1:0] key_q;
	logic [CNT_W-1:0] issue_q;
	logic [IDX_W-1:0] slot_q;
	logic [CNT_W-1:0] cnt_q;
	logic [dels_pkg::VALUE_W-1:0] rd_data_s1;
	logic rd_valid_s1;

	logic res_valid_q;
	dels_pkg::dels_status_t res_status_q, res_status_d;
	dels_pkg::dels_class_t  res_class_q, res_class_d;
	logic [dels_pkg::COUNT_W-1:0] res_count_q, res_count_d;

	logic accept, res_free, res_load, scan_start, rd_en, mem_we;
	logic full, empty;
	logic [IDX_W-1:0] waddr;
	logic [SUM_W-1:0] back_sum;
	logic [IDX_W-1:0] back_slot, front_dec, front_inc;
	logic [SAT_W-1:0] cnt_wide;

	function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
		return (s == IDX_W'(CAPACITY - 1)) ? '0 : s + 1'b1;
	endfunction

	assign res_free = !res_valid_q || rsp.ready;
	assign req.ready = (state_q == dels_pkg::ST_IDLE) && res_free;
	assign accept = req.valid && req.ready;

	assign full = (occ_q == CNT_W'(CAPACITY));
	assign empty = (occ_q == '0);

	assign back_sum = SUM_W'(front_q) + SUM_W'(occ_q);
	assign back_slot = (back_sum >= SUM_W'(CAPACITY)) ?
		IDX_W'(back_sum - SUM_W'(CAPACITY)) : back_sum[IDX_W-1:0];
	assign front_dec = (front_q == '0) ? IDX_W'(CAPACITY - 1) : front_q - 1'b1;
	assign front_inc = slot_inc(front_q);

	assign cnt_wide = SAT_W'(cnt_q);

	always_comb begin
		state_d = state_q;
		front_d = front_q;
		occ_d = occ_q;
		mem_we = 1'b0;
		waddr = back_slot;
		res_load = 1'b0;
		res_status_d = dels_pkg::STATUS_DONE;
		res_class_d = dels_pkg::CLASS_ABSENT;
		res_count_d = '0;
		scan_start = 1'b0;
		rd_en = 1'b0;
		unique case (state_q)
			dels_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (req.func)
						dels_pkg::FUNC_PUSH_BACK: begin
							res_load = 1'b1;
							if (full) begin
								res_status_d = dels_pkg::STATUS_FULL;
							end else begin
								mem_we = 1'b1;
								waddr = back_slot;
								occ_d = occ_q + 1'b1;
							end
						end
						dels_pkg::FUNC_PUSH_FRONT: begin
							res_load = 1'b1;
							if (full) begin
								res_status_d = dels_pkg::STATUS_FULL;
							end else begin
								mem_we = 1'b1;
								waddr = front_dec;
								front_d = front_dec;
								occ_d = occ_q + 1'b1;
							end
						end
						dels_pkg::FUNC_POP_FRONT: begin
							res_load = 1'b1;
							if (empty) begin
								res_status_d = dels_pkg::STATUS_EMPTY;
							end else begin
								front_d = front_inc;
								occ_d = occ_q - 1'b1;
							end
						end
						dels_pkg::FUNC_POP_BACK: begin
							res_load = 1'b1;
							if (empty) begin
								res_status_d = dels_pkg::STATUS_EMPTY;
							end else begin
								occ_d = occ_q - 1'b1;
							end
						end
						dels_pkg::FUNC_SEARCH: begin
							if (empty) begin
								res_load = 1'b1;
							end else begin
								scan_start = 1'b1;
								state_d = dels_pkg::ST_SCAN;
							end
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			dels_pkg::ST_SCAN: begin
				rd_en = (issue_q != occ_q);
				if (!rd_en && !rd_valid_s1 && res_free) begin
					res_load = 1'b1;
					state_d = dels_pkg::ST_IDLE;
					if (cnt_q == '0) begin
						res_class_d = dels_pkg::CLASS_ABSENT;
					end else if (cnt_q == CNT_W'(1)) begin
						res_class_d = dels_pkg::CLASS_UNIQUE;
					end else begin
						res_class_d = dels_pkg::CLASS_DUP;
					end
					res_count_d = (cnt_wide > SAT_W'(dels_pkg::COUNT_MAX)) ?
						dels_pkg::COUNT_W'(dels_pkg::COUNT_MAX) :
						cnt_wide[dels_pkg::COUNT_W-1:0];
				end
			end
			default: begin
				state_d = dels_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dels_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			occ_q <= '0;
			issue_q <= '0;
			slot_q <= '0;
			cnt_q <= '0;
			rd_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			front_q <= front_d;
			occ_q <= occ_d;
			rd_valid_s1 <= rd_en;
			if (scan_start) begin
				issue_q <= '0;
				slot_q <= front_q;
				cnt_q <= '0;
			end else begin
				if (rd_en) begin
					issue_q <= issue_q + 1'b1;
					slot_q <= slot_inc(slot_q);
				end
				if (rd_valid_s1 && (rd_data_s1 == key_q)) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_start) begin
			key_q <= req.value;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_class_q <= res_class_d;
			res_count_q <= res_count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entries_mem[waddr] <= req.value;
		end
		if (rd_en) begin
			rd_data_s1 <= entries_mem[slot_q];
		end
	end

	assign rsp.valid = res_valid_q;
	assign rsp.status = res_status_q;
	assign rsp.match_class = res_class_q;
	assign rsp.match_count = res_count_q;

endmodule

// File: src/dels_checker.sv
// Port-level checker of the double-ended list and its bind to the top level.
// Depends on dels_pkg and the macros in double_ended_list_with_search_defines.svh.
`include "double_ended_list_with_search_defines.svh"

module dels_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic [dels_pkg::FUNC_W-1:0]   func,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [dels_pkg::STATUS_W-1:0] status,
	input logic [dels_pkg::CLASS_W-1:0]  match_class,
	input logic [dels_pkg::COUNT_W-1:0]  match_count
);

	logic req_fire;
	logic simple_op;

	assign req_fire = req_valid && req_ready;
	assign simple_op = (func != dels_pkg::FUNC_SEARCH);

	`DELS_ASSERT_IMP(a_rsp_hold, rsp_valid && !rsp_ready, ##1 (rsp_valid && $stable(status) && $stable(match_class) && $stable(match_count)), "Stalled response word changed.")
	`DELS_ASSERT_IMP(a_simple_word, req_fire && simple_op, ##1 rsp_valid, "Queue operation gave no word on the next cycle.")
	`DELS_ASSERT_IMP(a_simple_clear, req_fire && simple_op, ##1 (match_class == dels_pkg::CLASS_ABSENT && match_count == '0), "Queue operation reported a match.")
	`DELS_ASSERT_IMP(a_class_count, rsp_valid, ((match_count == '0) == (match_class == dels_pkg::CLASS_ABSENT)) && ((match_count == 5'd1) == (match_class == dels_pkg::CLASS_UNIQUE)), "Match class disagrees with match count.")

endmodule

bind double_ended_list_with_search dels_checker u_dels_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.func        (req.func),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.match_class (rsp.match_class),
	.match_count (rsp.match_count)
);
